@@ rtl/htlm_pkg.sv @@
// Shared types and constants of the hierarchical tree lock manager.
`default_nettype none
package htlm_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ANC,
        S_DESC,
        S_WIPE,
        S_COMMIT
    } t_state;

    localparam logic [1:0] MODE_LOCK    = 2'd0;
    localparam logic [1:0] MODE_UNLOCK  = 2'd1;
    localparam logic [1:0] MODE_UPGRADE = 2'd2;

    localparam logic REG_ARITY = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic [5:0] ARITY_RST = 6'd2;
    localparam logic [6:0] COUNT_RST = 7'd64;

    localparam int OWNER_W = 16;
    localparam int LOCK_W  = OWNER_W + 1;

endpackage
`default_nettype wire

@@ rtl/htlm_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module htlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/hierarchical_tree_lock_manager.sv @@
// Lock manager top level: lock/owner RAM, parent RAM and request sequencer.
// Steps: an out-of-range or unknown-mode request is refused straight from idle; otherwise each
// ancestor is visited (self included), read then checked; lock and upgrade then scan the descendants
// and end the scan, upgrade then wipes the descendants and ends the wipe, and both then commit.
// Throughput: one request at a time; the next is taken the cycle after the result is accepted.
// Reset and every register write run a clearing pass over all MAX_NODES entries (no requests taken).
`default_nettype none
module hierarchical_tree_lock_manager #(
    parameter int MAX_NODES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [5:0]  i_node_index,
    input  wire logic [15:0] i_user_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_granted
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int RW = IW + 7;

    htlm_pkg::t_state r_state, n_state;
    logic [5:0]  r_arity, n_arity;
    logic [6:0]  r_count, n_count;
    logic [IW-1:0] r_ptr, n_ptr;
    logic [IW-1:0] r_par, n_par;
    logic [5:0]  r_sub, n_sub;
    logic [1:0]  r_mode, n_mode;
    logic [IW-1:0] r_idx, n_idx;
    logic [15:0] r_user, n_user;
    logic [IW-1:0] r_p, n_p;
    logic        r_ph, n_ph;
    logic        r_self, n_self;
    logic        r_found, n_found;
    logic [RW-1:0] r_lo, n_lo;
    logic [RW-1:0] r_hi, n_hi;
    logic [RW-1:0] r_j, n_j;
    logic        r_ovalid, n_ovalid;
    logic        r_granted, n_granted;

    logic [5:0]    a_eff;
    logic [RW-1:0] n_eff;
    logic          cfg_wr;
    logic          accept;
    logic          unl_ok;
    logic [RW+5:0] idx_prod, lo_prod, hi_prod;
    logic [RW-1:0] first_lo, first_hi;

    logic                        lk_we;
    logic [IW-1:0]               lk_addr;
    logic [htlm_pkg::LOCK_W-1:0] lk_wdata, lk_q;
    logic                        pa_we;
    logic [IW-1:0]               pa_addr, pa_wdata, pa_q;

    htlm_ram #(.WIDTH(htlm_pkg::LOCK_W), .DEPTH(MAX_NODES)) u_lock_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_addr  (lk_addr),
        .i_wdata (lk_wdata),
        .o_rdata (lk_q)
    );

    htlm_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (pa_we),
        .i_addr  (pa_addr),
        .i_wdata (pa_wdata),
        .o_rdata (pa_q)
    );

    assign a_eff  = (r_arity == 6'd0) ? 6'd1 : r_arity;
    assign n_eff  = (RW'(r_count) > RW'(MAX_NODES)) ? RW'(MAX_NODES) : RW'(r_count);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_ready = (r_state == htlm_pkg::S_IDLE) && !r_ovalid;
    assign accept  = i_valid && o_ready;
    assign o_valid   = r_ovalid;
    assign o_granted = r_granted;
    assign unl_ok = lk_q[htlm_pkg::LOCK_W-1] && (lk_q[htlm_pkg::OWNER_W-1:0] == r_user);

    assign idx_prod = RW'(r_idx) * a_eff;
    assign lo_prod  = r_lo * a_eff;
    assign hi_prod  = r_hi * a_eff;
    assign first_lo = RW'(idx_prod) + RW'(1);
    assign first_hi = RW'(idx_prod) + RW'(a_eff);

    always_comb begin
        case (paddr[2])
            htlm_pkg::REG_ARITY: prdata = {26'd0, r_arity};
            htlm_pkg::REG_COUNT: prdata = {25'd0, r_count};
            default:             prdata = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_arity   = r_arity;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_par     = r_par;
        n_sub     = r_sub;
        n_mode    = r_mode;
        n_idx     = r_idx;
        n_user    = r_user;
        n_p       = r_p;
        n_ph      = r_ph;
        n_self    = r_self;
        n_found   = r_found;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_j       = r_j;
        n_ovalid  = r_ovalid && !i_ready;
        n_granted = r_granted;
        case (r_state)
            htlm_pkg::S_CLEAR: begin
                n_ptr = r_ptr + IW'(1);
                if (r_ptr != '0) begin
                    if (r_sub == a_eff - 6'd1) begin
                        n_sub = 6'd0;
                        n_par = r_par + IW'(1);
                    end else begin
                        n_sub = r_sub + 6'd1;
                    end
                end
                if (r_ptr == IW'(MAX_NODES - 1)) begin
                    n_state = htlm_pkg::S_IDLE;
                end
            end
            htlm_pkg::S_IDLE: begin
                if (accept) begin
                    n_mode = i_mode;
                    n_idx  = IW'(i_node_index);
                    n_user = i_user_id;
                    n_p    = IW'(i_node_index);
                    n_ph   = 1'b0;
                    n_self = 1'b1;
                    if ((RW'(i_node_index) < n_eff) &&
                        (i_mode inside {htlm_pkg::MODE_LOCK, htlm_pkg::MODE_UNLOCK,
                                        htlm_pkg::MODE_UPGRADE})) begin
                        n_state = htlm_pkg::S_ANC;
                    end else begin
                        n_ovalid  = 1'b1;
                        n_granted = 1'b0;
                    end
                end
            end
            htlm_pkg::S_ANC: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else if (r_self && r_mode == htlm_pkg::MODE_UNLOCK) begin
                    n_ovalid  = 1'b1;
                    n_granted = unl_ok;
                    n_state   = htlm_pkg::S_IDLE;
                end else if (lk_q[htlm_pkg::LOCK_W-1]) begin
                    n_ovalid  = 1'b1;
                    n_granted = 1'b0;
                    n_state   = htlm_pkg::S_IDLE;
                end else if (r_p == '0) begin
                    n_lo    = first_lo;
                    n_hi    = first_hi;
                    n_j     = first_lo;
                    n_ph    = 1'b0;
                    n_found = 1'b0;
                    n_state = htlm_pkg::S_DESC;
                end else begin
                    n_p    = pa_q;
                    n_self = 1'b0;
                    n_ph   = 1'b0;
                end
            end
            htlm_pkg::S_DESC: begin
                if (!r_ph) begin
                    if (r_j >= n_eff) begin
                        if (r_mode == htlm_pkg::MODE_LOCK) begin
                            n_state = htlm_pkg::S_COMMIT;
                        end else if (r_found) begin
                            n_lo    = first_lo;
                            n_hi    = first_hi;
                            n_j     = first_lo;
                            n_state = htlm_pkg::S_WIPE;
                        end else begin
                            n_ovalid  = 1'b1;
                            n_granted = 1'b0;
                            n_state   = htlm_pkg::S_IDLE;
                        end
                    end else begin
                        n_ph = 1'b1;
                    end
                end else begin
                    n_ph = 1'b0;
                    if (lk_q[htlm_pkg::LOCK_W-1] &&
                        (r_mode == htlm_pkg::MODE_LOCK ||
                         lk_q[htlm_pkg::OWNER_W-1:0] != r_user)) begin
                        n_ovalid  = 1'b1;
                        n_granted = 1'b0;
                        n_state   = htlm_pkg::S_IDLE;
                    end else begin
                        if (lk_q[htlm_pkg::LOCK_W-1]) begin
                            n_found = 1'b1;
                        end
                        if (r_j == r_hi) begin
                            n_lo = RW'(lo_prod) + RW'(1);
                            n_hi = RW'(hi_prod) + RW'(a_eff);
                            n_j  = RW'(lo_prod) + RW'(1);
                        end else begin
                            n_j = r_j + RW'(1);
                        end
                    end
                end
            end
            htlm_pkg::S_WIPE: begin
                if (r_j >= n_eff) begin
                    n_state = htlm_pkg::S_COMMIT;
                end else if (r_j == r_hi) begin
                    n_lo = RW'(lo_prod) + RW'(1);
                    n_hi = RW'(hi_prod) + RW'(a_eff);
                    n_j  = RW'(lo_prod) + RW'(1);
                end else begin
                    n_j = r_j + RW'(1);
                end
            end
            htlm_pkg::S_COMMIT: begin
                n_ovalid  = 1'b1;
                n_granted = 1'b1;
                n_state   = htlm_pkg::S_IDLE;
            end
            default: begin
                n_state = htlm_pkg::S_CLEAR;
            end
        endcase
        if (cfg_wr) begin
            case (paddr[2])
                htlm_pkg::REG_ARITY: n_arity = pwdata[5:0];
                htlm_pkg::REG_COUNT: n_count = pwdata[6:0];
                default:             n_count = r_count;
            endcase
            n_state = htlm_pkg::S_CLEAR;
            n_ptr   = '0;
            n_par   = '0;
            n_sub   = 6'd0;
        end
    end

    // memory control
    always_comb begin
        lk_we    = 1'b0;
        lk_addr  = r_idx;
        lk_wdata = '0;
        pa_we    = 1'b0;
        pa_addr  = r_p;
        pa_wdata = r_par;
        case (r_state)
            htlm_pkg::S_CLEAR: begin
                lk_we   = 1'b1;
                lk_addr = r_ptr;
                pa_we   = 1'b1;
                pa_addr = r_ptr;
            end
            htlm_pkg::S_ANC: begin
                if (!r_ph) begin
                    lk_addr = r_p;
                end else if (r_self && r_mode == htlm_pkg::MODE_UNLOCK && unl_ok) begin
                    lk_we = 1'b1;
                end
            end
            htlm_pkg::S_DESC: begin
                lk_addr = r_j[IW-1:0];
            end
            htlm_pkg::S_WIPE: begin
                if (r_j < n_eff) begin
                    lk_we   = 1'b1;
                    lk_addr = r_j[IW-1:0];
                end
            end
            htlm_pkg::S_COMMIT: begin
                lk_we    = 1'b1;
                lk_wdata = {1'b1, r_user};
            end
            default: begin
                lk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= htlm_pkg::S_CLEAR;
            r_arity  <= htlm_pkg::ARITY_RST;
            r_count  <= htlm_pkg::COUNT_RST;
            r_ptr    <= '0;
            r_par    <= '0;
            r_sub    <= 6'd0;
            r_ph     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_arity  <= n_arity;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_par    <= n_par;
            r_sub    <= n_sub;
            r_ph     <= n_ph;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_idx     <= n_idx;
        r_user    <= n_user;
        r_p       <= n_p;
        r_self    <= n_self;
        r_found   <= n_found;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_j       <= n_j;
        r_granted <= n_granted;
    end

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("request taken while a result is pending");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htlm_pkg::S_CLEAR) |-> !o_ready)
        else $error("request taken during clearing pass");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state == htlm_pkg::S_CLEAR))
        else $error("register write did not start clearing pass");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) != htlm_pkg::S_CLEAR))
        else $error("result raised during clearing pass");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for the tree lock manager: directed table, then random requests checked by a model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 64;
    localparam logic [1:0] MODE_BAD = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  node;
        logic [15:0] user;
        logic        has_exp;
        logic        exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [5:0]  i_node_index = '0;
    logic [15:0] i_user_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_granted;

    hierarchical_tree_lock_manager uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    int unsigned cfg_arity = htlm_pkg::ARITY_RST;
    int unsigned cfg_count = htlm_pkg::COUNT_RST;
    bit          held[NODES];
    logic [15:0] holder[NODES];
    logic [5:0]  anc_cnt[NODES];
    logic [5:0]  desc_cnt[NODES];

    logic        grant_q[$];
    int          errors = 0;
    int          results = 0;
    int          grants = 0;
    int          sent = 0;

    function automatic int unsigned eff_arity();
        return cfg_arity == 0 ? 1 : cfg_arity;
    endfunction

    function automatic int unsigned eff_count();
        return cfg_count > NODES ? NODES : cfg_count;
    endfunction

    function automatic void wipe_tree();
        for (int k = 0; k < NODES; k++) begin
            held[k] = 0;
            holder[k] = '0;
            anc_cnt[k] = '0;
            desc_cnt[k] = '0;
        end
    endfunction

    function automatic bit is_below(int unsigned j, int unsigned i);
        int unsigned a;
        a = eff_arity();
        if (j <= i) return 0;
        while (j > i) j = (j - 1) / a;
        return j == i;
    endfunction

    function automatic void bump(int unsigned i, logic [5:0] d);
        int unsigned p;
        p = i;
        while (p > 0) begin
            p = (p - 1) / eff_arity();
            desc_cnt[p] = desc_cnt[p] + d;
        end
        for (int unsigned j = i + 1; j < eff_count(); j++)
            if (is_below(j, i)) anc_cnt[j] = anc_cnt[j] + d;
    endfunction

    function automatic void take(int unsigned i, logic [15:0] u);
        bump(i, 6'd1);
        held[i] = 1;
        holder[i] = u;
    endfunction

    function automatic void drop(int unsigned i);
        bump(i, 6'h3f);
        held[i] = 0;
        holder[i] = '0;
    endfunction

    function automatic logic predict_grant(logic [1:0] m, int unsigned i, logic [15:0] u);
        if (i >= eff_count()) return 1'b0;
        case (m)
            htlm_pkg::MODE_LOCK: begin
                if (held[i] || anc_cnt[i] != 0 || desc_cnt[i] != 0) return 1'b0;
                take(i, u);
                return 1'b1;
            end
            htlm_pkg::MODE_UNLOCK: begin
                if (!held[i] || holder[i] != u) return 1'b0;
                drop(i);
                return 1'b1;
            end
            htlm_pkg::MODE_UPGRADE: begin
                if (held[i] || anc_cnt[i] != 0 || desc_cnt[i] == 0) return 1'b0;
                for (int unsigned j = i + 1; j < eff_count(); j++)
                    if (held[j] && is_below(j, i) && holder[j] != u) return 1'b0;
                for (int unsigned j = i + 1; j < eff_count(); j++)
                    if (held[j] && is_below(j, i)) drop(j);
                take(i, u);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic write_reg(logic regsel, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {regsel, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (regsel == htlm_pkg::REG_ARITY) cfg_arity = val[5:0];
        else cfg_count = val[6:0];
        wipe_tree();
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_request(logic [1:0] m, logic [5:0] n, logic [15:0] u,
                                bit has_exp, logic exp);
        logic g;
        int unsigned gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1; i_mode <= m; i_node_index <= n; i_user_id <= u;
        do @(posedge i_clk); while (!o_ready);
        g = predict_grant(m, n, u);
        if (has_exp && g !== exp) begin
            errors++;
            if (errors <= 10)
                $display("table row mode %0d node %0d: expected %0b predicted %0b",
                         m, n, exp, g);
        end
        grant_q = {grant_q, g};
        sent++;
    endtask

    // response side
    initial begin
        logic e;
        int unsigned gap;
        forever begin
            gap = $urandom_range(0, 3);
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results++;
            if (grant_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected grant %0b", o_granted);
            end else begin
                e = grant_q.pop_front();
                if (o_granted === 1'b1) grants++;
                if (o_granted !== e) begin
                    errors++;
                    if (errors <= 10)
                        $display("granted mismatch: expected %0b actual %0b", e, o_granted);
                end
            end
        end
    end

    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end

    t_row dir_tab[] = '{
        '{htlm_pkg::MODE_UNLOCK, 6'd0, 16'h0000, 1'b1, 1'b0},
        '{htlm_pkg::MODE_LOCK, 6'd63, 16'hffff, 1'b1, 1'b1},
        '{htlm_pkg::MODE_LOCK, 6'd0, 16'h0001, 1'b1, 1'b0},
        '{htlm_pkg::MODE_LOCK, 6'd31, 16'hffff, 1'b1, 1'b0},
        '{htlm_pkg::MODE_UPGRADE, 6'd31, 16'hffff, 1'b1, 1'b1},
        '{htlm_pkg::MODE_UPGRADE, 6'd0, 16'h0001, 1'b1, 1'b0},
        '{htlm_pkg::MODE_UNLOCK, 6'd31, 16'h0001, 1'b1, 1'b0},
        '{htlm_pkg::MODE_UNLOCK, 6'd31, 16'hffff, 1'b1, 1'b1},
        '{MODE_BAD, 6'd5, 16'h1234, 1'b1, 1'b0},
        '{htlm_pkg::MODE_LOCK, 6'd3, 16'h00aa, 1'b0, 1'b0},
        '{htlm_pkg::MODE_LOCK, 6'd4, 16'h00aa, 1'b0, 1'b0},
        '{htlm_pkg::MODE_UPGRADE, 6'd1, 16'h00aa, 1'b0, 1'b0},
        '{htlm_pkg::MODE_UPGRADE, 6'd0, 16'h00bb, 1'b0, 1'b0},
        '{htlm_pkg::MODE_UPGRADE, 6'd2, 16'h00bb, 1'b1, 1'b0},
        '{htlm_pkg::MODE_UNLOCK, 6'd1, 16'h00aa, 1'b0, 1'b0}
    };

    initial begin
        int unsigned ar_set[6];
        int unsigned nc_set[6];
        logic [1:0]  m;
        logic [5:0]  n;
        logic [15:0] u;
        logic [15:0] users[4];
        ar_set = '{1, 63, 0, 3, 2, 8};
        nc_set = '{64, 1, 0, 127, 13, 40};
        wipe_tree();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (NODES + 4) @(posedge i_clk);
        foreach (dir_tab[r])
            send_request(dir_tab[r].mode, dir_tab[r].node, dir_tab[r].user,
                         dir_tab[r].has_exp, dir_tab[r].exp);
        settle();
        write_reg(htlm_pkg::REG_COUNT, 32'd5);
        send_request(htlm_pkg::MODE_LOCK, 6'd5, 16'h0001, 1'b1, 1'b0);
        send_request(htlm_pkg::MODE_LOCK, 6'd4, 16'h0001, 1'b1, 1'b1);
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_reg(htlm_pkg::REG_ARITY, ar_set[ph]);
            write_reg(htlm_pkg::REG_COUNT, nc_set[ph]);
            repeat (NODES + 4) @(posedge i_clk);
            for (int k = 0; k < 4; k++) users[k] = $urandom();
            for (int it = 0; it < 225; it++) begin
                if (it == 110) settle();
                m = $urandom_range(0, 9) == 0 ? MODE_BAD : 2'($urandom_range(0, 2));
                n = $urandom_range(0, 5) == 0 ? 6'($urandom()) :
                    6'($urandom_range(0, (nc_set[ph] > 1 && nc_set[ph] < 64) ?
                                         nc_set[ph] - 1 : 63));
                u = $urandom_range(0, 7) == 0 ? 16'($urandom()) : users[$urandom_range(0, 3)];
                send_request(m, n, u, 1'b0, 1'b0);
            end
        end
        settle();
        $display("sent %0d requests over 8 tree shapes, %0d results, %0d granted",
                 sent, results, grants);
        if (errors == 0 && grant_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d errors, %0d left waiting", errors, grant_q.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
